/* hdl/tpc_pkg.sv */
`timescale 1ns / 1ps

package tpc_pkg;

  // Geometry of the datapath
  localparam int SAMPLES_PER_TARGET = 3;
  localparam int COORD_BITS         = 12;
  localparam int FRACTION_BITS      = 16;

  localparam int RES_W   = 13;
  localparam int INSET_W = 8;
  localparam int COEF_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam int CNT_W = (SAMPLES_PER_TARGET > 1) ? $clog2(SAMPLES_PER_TARGET) : 1;
  localparam int SUM_W = COORD_BITS + CNT_W;

  // Target coordinates carry one sign bit over the resolution
  localparam int TGT_W = RES_W + 1;

  // Signed numerator of the coefficient solve, fraction included
  localparam int NUM_W = RES_W + COORD_BITS + 2 + FRACTION_BITS;
  // Signed divisor: difference of two corner averages
  localparam int DEN_W = COORD_BITS + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  localparam int MUL_A_W = COEF_W;
  localparam int MUL_B_W = SUM_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Corner average by reciprocal multiplication: exact floor for every sample sum
  localparam int AVG_SHIFT = SUM_W + CNT_W + 1;
  localparam logic signed [MUL_A_W-1:0] AVG_RECIP =
    MUL_A_W'(((longint'(1) << AVG_SHIFT) + SAMPLES_PER_TARGET - 1) / SAMPLES_PER_TARGET);

  localparam logic [RES_W-1:0]   HRES_RESET  = RES_W'(320);
  localparam logic [RES_W-1:0]   VRES_RESET  = RES_W'(240);
  localparam logic [INSET_W-1:0] INSET_RESET = INSET_W'(30);
  localparam logic [RES_W-1:0]   COORD_MAX   = RES_W'((1 << COORD_BITS) - 1);

  localparam logic signed [COEF_W-1:0] GAIN_ONE = COEF_W'(1 << FRACTION_BITS);

  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(SAMPLES_PER_TARGET - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HRES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VRES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INSET = 2'd2;

  // Input action codes
  localparam logic ACT_TOUCH = 1'b0;
  localparam logic ACT_START = 1'b1;

  typedef enum logic [1:0] {
    MODE_NORMAL      = 2'd0,
    MODE_UPPER_LEFT  = 2'd1,
    MODE_LOWER_RIGHT = 2'd2,
    MODE_WAIT_LEAVE  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_MUL,
    CS_CLAMP,
    CS_SUM,
    CS_AVG,
    CS_SOLVE_CHK,
    CS_SOLVE_M1,
    CS_SOLVE_M2,
    CS_OFF_ISS,
    CS_OFF_WAIT,
    CS_GAIN_ISS,
    CS_GAIN_WAIT,
    CS_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX
  } div_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] numer;
    logic signed [DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [COEF_W-1:0] quot;
  } div_rsp_t;

endpackage

/* hdl/two_point_touch_calibrator.sv */
`timescale 1ns / 1ps
// Two-point touch calibrator. One item in flight; in_ready is high only while idle, so
// a new item is taken only once the last one's result has entered the output register.
// Solves run on the 43-step serial divider; a result waiting in the output register holds
// the next one. Reset (rst_n low, synchronous): normal mode, unity gains, zero offsets,
// default config.

module two_point_touch_calibrator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [tpc_pkg::COORD_BITS-1:0] in_raw_x,
  input  logic [tpc_pkg::COORD_BITS-1:0] in_raw_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tpc_pkg::COORD_BITS-1:0] out_point_x,
  output logic [tpc_pkg::COORD_BITS-1:0] out_point_y,
  output logic [1:0]                     out_phase,
  output logic [1:0]                     out_touches_left,
  output logic                           out_coefficients_updated,
  output logic                           out_divide_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpc_pkg::RES_W-1:0]      cfg_data
);
  import tpc_pkg::*;

  ctl_state_t state_r, state_nxt;

  // Configuration
  logic [RES_W-1:0]   hres_r, vres_r;
  logic [INSET_W-1:0] inset_r;

  // Calibration state and coefficients (Q15.16)
  mode_t                    mode_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [COEF_W-1:0] gain_x_r, offset_x_r, gain_y_r, offset_y_r;

  // Sample store and corner averages
  logic [COORD_BITS-1:0] samp_x_r [SAMPLES_PER_TARGET];
  logic [COORD_BITS-1:0] samp_y_r [SAMPLES_PER_TARGET];
  logic [COORD_BITS-1:0] avg_ul_x_r, avg_ul_y_r, avg_lr_x_r, avg_lr_y_r;

  // Working registers for the current item
  logic [COORD_BITS-1:0]    raw_x_r, raw_y_r;
  logic [COORD_BITS-1:0]    res_x_r, res_y_r;
  logic                     upd_r, derr_r;
  logic                     axis_r;
  logic [CNT_W-1:0]         sidx_r;
  logic [SUM_W-1:0]         sum_x_r, sum_y_r;
  logic signed [PROD_W-1:0] prod_r;

  // Result register
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_point_x_r, out_point_y_r;
  logic [1:0]            out_phase_r, out_left_r;
  logic                  out_upd_r, out_derr_r;

  logic accept;
  logic out_free;

  // Per-axis selection
  logic [RES_W-1:0]         sel_res;
  logic [COORD_BITS-1:0]    sel_raw;
  logic signed [COEF_W-1:0] sel_gain, sel_off;
  logic [COORD_BITS-1:0]    sel_m1, sel_m2;
  logic signed [TGT_W-1:0]  tgt1, tgt2;
  logic signed [TGT_W:0]    tgt_diff;
  logic signed [DEN_W-1:0]  sel_den;
  logic                     any_zero;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  // Output mapping
  logic signed [PROD_W:0] clamp_sum;
  logic signed [PROD_W:0] clamp_v;
  logic [RES_W-1:0]       hi_raw, hi_c;
  logic [COORD_BITS-1:0]  clamp_res;

  logic [CNT_W:0] left_ext;
  logic [1:0]     left_val;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready  = (state_r == CS_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  assign out_valid                = out_valid_r;
  assign out_point_x              = out_point_x_r;
  assign out_point_y              = out_point_y_r;
  assign out_phase                = out_phase_r;
  assign out_touches_left         = out_left_r;
  assign out_coefficients_updated = out_upd_r;
  assign out_divide_error         = out_derr_r;

  // Axis muxes: axis 0 is x, axis 1 is y
  always_comb begin
    sel_res  = axis_r ? vres_r     : hres_r;
    sel_raw  = axis_r ? raw_y_r    : raw_x_r;
    sel_gain = axis_r ? gain_y_r   : gain_x_r;
    sel_off  = axis_r ? offset_y_r : offset_x_r;
    sel_m1   = axis_r ? avg_ul_y_r : avg_ul_x_r;
    sel_m2   = axis_r ? avg_lr_y_r : avg_lr_x_r;
    // Upper-left target sits at the inset, lower-right at resolution minus inset
    tgt1     = $signed({{(TGT_W - INSET_W){1'b0}}, inset_r});
    tgt2     = $signed({1'b0, sel_res}) - tgt1;
    tgt_diff = (TGT_W+1)'(tgt1) - (TGT_W+1)'(tgt2);
    sel_den  = $signed({1'b0, sel_m1}) - $signed({1'b0, sel_m2});
    any_zero = (avg_ul_x_r == avg_lr_x_r) || (avg_ul_y_r == avg_lr_y_r);
  end

  // Multiplier operands follow the step in hand
  always_comb begin
    case (state_r)
      CS_AVG: begin
        // Sample sum times the reciprocal of the sample count
        mul_a = AVG_RECIP;
        mul_b = $signed({1'b0, axis_r ? sum_y_r : sum_x_r});
      end
      CS_SOLVE_M1: begin
        mul_a = MUL_A_W'(tgt2);
        mul_b = $signed(MUL_B_W'({1'b0, sel_m1}));
      end
      CS_SOLVE_M2: begin
        mul_a = MUL_A_W'(tgt1);
        mul_b = $signed(MUL_B_W'({1'b0, sel_m2}));
      end
      default: begin
        mul_a = sel_gain;
        mul_b = $signed(MUL_B_W'({1'b0, sel_raw}));
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Floor by the fraction, then clamp to 0..min(res-1, coordinate max)
  always_comb begin
    clamp_sum = (PROD_W+1)'(prod_r) + (PROD_W+1)'(sel_off);
    clamp_v   = clamp_sum >>> FRACTION_BITS;
    hi_raw    = (sel_res == '0) ? '0 : sel_res - RES_W'(1);
    hi_c      = (hi_raw > COORD_MAX) ? COORD_MAX : hi_raw;
    if (clamp_v < 0) begin
      clamp_res = '0;
    end else if (clamp_v > $signed((PROD_W+1)'(hi_c))) begin
      clamp_res = hi_c[COORD_BITS-1:0];
    end else begin
      clamp_res = clamp_v[COORD_BITS-1:0];
    end
  end

  // Divider requests: offset and gain per axis
  always_comb begin
    div_req.start = (state_r == CS_OFF_ISS) || (state_r == CS_GAIN_ISS);
    case (state_r)
      CS_OFF_ISS: begin
        div_req.numer = $signed({prod_r[NUM_W-FRACTION_BITS-1:0], {FRACTION_BITS{1'b0}}});
        div_req.denom = sel_den;
      end
      default: begin
        div_req.numer = $signed(NUM_W'(tgt_diff)) <<< FRACTION_BITS;
        div_req.denom = sel_den;
      end
    endcase
  end

  // Touches still needed, saturating at three
  always_comb begin
    left_ext = (CNT_W+1)'(cnt_r) + (CNT_W+1)'(1);
    if (mode_r == MODE_UPPER_LEFT || mode_r == MODE_LOWER_RIGHT) begin
      left_val = (left_ext > (CNT_W+1)'(3)) ? 2'd3 : left_ext[1:0];
    end else begin
      left_val = 2'd0;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_START) begin
            state_nxt = CS_DONE;
          end else begin
            case (mode_r)
              MODE_NORMAL:      state_nxt = CS_MUL;
              MODE_UPPER_LEFT,
              MODE_LOWER_RIGHT: state_nxt = (cnt_r == '0) ? CS_SUM : CS_DONE;
              MODE_WAIT_LEAVE:  state_nxt = CS_SOLVE_CHK;
              default:          state_nxt = CS_DONE;
            endcase
          end
        end
      end
      CS_MUL:       state_nxt = CS_CLAMP;
      CS_CLAMP:     state_nxt = axis_r ? CS_DONE : CS_MUL;
      CS_SUM:       if (sidx_r == CNT_START) state_nxt = CS_AVG;
      CS_AVG:       state_nxt = axis_r ? CS_DONE : CS_AVG;
      CS_SOLVE_CHK: state_nxt = any_zero ? CS_DONE : CS_SOLVE_M1;
      CS_SOLVE_M1:  state_nxt = CS_SOLVE_M2;
      CS_SOLVE_M2:  state_nxt = CS_OFF_ISS;
      CS_OFF_ISS:   state_nxt = CS_OFF_WAIT;
      CS_OFF_WAIT:  if (div_rsp.done) state_nxt = CS_GAIN_ISS;
      CS_GAIN_ISS:  state_nxt = CS_GAIN_WAIT;
      CS_GAIN_WAIT: if (div_rsp.done) state_nxt = axis_r ? CS_DONE : CS_SOLVE_M1;
      CS_DONE:      if (out_free) state_nxt = CS_IDLE;
      default:      state_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state, coefficients and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hres_r      <= HRES_RESET;
      vres_r      <= VRES_RESET;
      inset_r     <= INSET_RESET;
      mode_r      <= MODE_NORMAL;
      cnt_r       <= CNT_START;
      gain_x_r    <= GAIN_ONE;
      gain_y_r    <= GAIN_ONE;
      offset_x_r  <= '0;
      offset_y_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_HRES:  hres_r  <= cfg_data;
          CFG_VRES:  vres_r  <= cfg_data;
          CFG_INSET: inset_r <= cfg_data[INSET_W-1:0];
          default: ;
        endcase
      end

      // Drop the result once taken, unless the next one lands in the same cycle
      if (out_valid_r && out_ready && state_r != CS_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        CS_IDLE: begin
          if (accept) begin
            if (in_action == ACT_START) begin
              // Restart at the upper-left target; keep the old coefficients
              mode_r <= MODE_UPPER_LEFT;
              cnt_r  <= CNT_START;
            end else if (mode_r == MODE_UPPER_LEFT || mode_r == MODE_LOWER_RIGHT) begin
              if (cnt_r != '0) begin
                cnt_r <= cnt_r - CNT_W'(1);
              end
            end
          end
        end
        CS_AVG: begin
          if (axis_r) begin
            mode_r <= (mode_r == MODE_UPPER_LEFT) ? MODE_LOWER_RIGHT : MODE_WAIT_LEAVE;
            cnt_r  <= CNT_START;
          end
        end
        CS_SOLVE_CHK: begin
          // Coinciding corners: keep all four coefficients and drop back to normal
          if (any_zero) begin
            mode_r <= MODE_NORMAL;
            cnt_r  <= CNT_START;
          end
        end
        CS_OFF_WAIT: begin
          if (div_rsp.done) begin
            if (axis_r) begin
              offset_y_r <= div_rsp.quot;
            end else begin
              offset_x_r <= div_rsp.quot;
            end
          end
        end
        CS_GAIN_WAIT: begin
          if (div_rsp.done) begin
            if (axis_r) begin
              gain_y_r <= div_rsp.quot;
              mode_r   <= MODE_NORMAL;
              cnt_r    <= CNT_START;
            end else begin
              gain_x_r <= div_rsp.quot;
            end
          end
        end
        CS_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      CS_IDLE: begin
        if (accept) begin
          raw_x_r <= in_raw_x;
          raw_y_r <= in_raw_y;
          res_x_r <= in_raw_x;
          res_y_r <= in_raw_y;
          upd_r   <= 1'b0;
          derr_r  <= 1'b0;
          axis_r  <= 1'b0;
          sidx_r  <= '0;
          sum_x_r <= '0;
          sum_y_r <= '0;
          if (in_action == ACT_TOUCH &&
              (mode_r == MODE_UPPER_LEFT || mode_r == MODE_LOWER_RIGHT)) begin
            samp_x_r[cnt_r] <= in_raw_x;
            samp_y_r[cnt_r] <= in_raw_y;
          end
        end
      end
      CS_MUL: prod_r <= mul_p;
      CS_CLAMP: begin
        if (axis_r) begin
          res_y_r <= clamp_res;
        end else begin
          res_x_r <= clamp_res;
        end
        axis_r <= ~axis_r;
      end
      CS_SUM: begin
        sum_x_r <= sum_x_r + SUM_W'(samp_x_r[sidx_r]);
        sum_y_r <= sum_y_r + SUM_W'(samp_y_r[sidx_r]);
        sidx_r  <= sidx_r + CNT_W'(1);
      end
      CS_AVG: begin
        case ({mode_r == MODE_LOWER_RIGHT, axis_r})
          2'b00:   avg_ul_x_r <= mul_p[AVG_SHIFT +: COORD_BITS];
          2'b01:   avg_ul_y_r <= mul_p[AVG_SHIFT +: COORD_BITS];
          2'b10:   avg_lr_x_r <= mul_p[AVG_SHIFT +: COORD_BITS];
          default: avg_lr_y_r <= mul_p[AVG_SHIFT +: COORD_BITS];
        endcase
        axis_r <= ~axis_r;
      end
      CS_SOLVE_CHK: begin
        if (any_zero) begin
          derr_r <= 1'b1;
        end
      end
      CS_SOLVE_M1: prod_r <= mul_p;
      CS_SOLVE_M2: prod_r <= prod_r - mul_p;
      CS_GAIN_WAIT: begin
        if (div_rsp.done) begin
          axis_r <= ~axis_r;
          if (axis_r) begin
            upd_r <= 1'b1;
          end
        end
      end
      CS_DONE: begin
        if (out_free) begin
          out_point_x_r <= res_x_r;
          out_point_y_r <= res_y_r;
          out_phase_r   <= mode_r;
          out_left_r    <= left_val;
          out_upd_r     <= upd_r;
          out_derr_r    <= derr_r;
        end
      end
      default: ;
    endcase
  end

  // A result never both installs coefficients and reports a failed solve
  a_upd_derr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_coefficients_updated && out_divide_error))
    else $error("updated and divide error both set");

  // Installing coefficients always lands back in normal mode
  a_upd_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_coefficients_updated |-> out_phase == MODE_NORMAL)
    else $error("coefficients installed outside normal mode");

  // No touches pending outside the two target phases
  a_left_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_phase == MODE_NORMAL || out_phase == MODE_WAIT_LEAVE)
      |-> out_touches_left == 2'd0)
    else $error("touches left outside a target phase");

  // The divider finishes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == CS_OFF_WAIT || state_r == CS_GAIN_WAIT))
    else $error("divider result with no waiting step");

endmodule

/* hdl/tpc_div.sv */
`timescale 1ns / 1ps

// Serial signed divider: one quotient bit a cycle, floored, saturated to 32 bits.
module tpc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  tpc_pkg::div_req_t req,
  output tpc_pkg::div_rsp_t rsp
);
  import tpc_pkg::*;

  div_state_t state_r, state_nxt;
  logic [NUM_W-1:0]     num_r;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W-1:0]     rem_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  logic [NUM_W-1:0]     n_mag;
  logic [DEN_W-1:0]     d_mag;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_sub;
  logic                 sub_ok;
  logic signed [NUM_W:0] q_s;
  logic signed [NUM_W:0] q_max;
  logic signed [NUM_W:0] q_min;

  assign n_mag   = req.numer[NUM_W-1] ? NUM_W'(-req.numer) : NUM_W'(req.numer);
  assign d_mag   = req.denom[DEN_W-1] ? DEN_W'(-req.denom) : DEN_W'(req.denom);
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign sub_ok  = (rem_sh >= {1'b0, den_r});

  assign q_max = $signed({{(NUM_W - 31){1'b0}}, 32'h7fff_ffff});
  assign q_min = $signed({{(NUM_W - 31){1'b1}}, 32'h8000_0000});

  // Floor correction for a negative quotient with a remainder
  always_comb begin
    if (neg_r) begin
      q_s = -$signed({1'b0, num_r}) - ((rem_r != '0) ? (NUM_W+1)'(1) : (NUM_W+1)'(0));
    end else begin
      q_s = $signed({1'b0, num_r});
    end
  end

  always_comb begin
    rsp.done = (state_r == DIV_FIX);
    if (q_s > q_max) begin
      rsp.quot = q_max[COEF_W-1:0];
    end else if (q_s < q_min) begin
      rsp.quot = q_min[COEF_W-1:0];
    end else begin
      rsp.quot = q_s[COEF_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DIV_IDLE: if (req.start) state_nxt = DIV_RUN;
      DIV_RUN:  if (cnt_r == DIV_CNT_W'(1)) state_nxt = DIV_FIX;
      DIV_FIX:  state_nxt = DIV_IDLE;
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DIV_IDLE && req.start) begin
      num_r <= n_mag;
      den_r <= d_mag;
      rem_r <= '0;
      neg_r <= req.numer[NUM_W-1] ^ req.denom[DEN_W-1];
      cnt_r <= DIV_CNT_W'(NUM_W);
    end else if (state_r == DIV_RUN) begin
      rem_r <= sub_ok ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], sub_ok};
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

endmodule
